// File: rtl/iphpf_pkg.sv
`default_nettype none

package iphpf_pkg;

  localparam int ETH_HDR_BYTES  = 14;
  localparam int ICMP_HDR_BYTES = 8;
  localparam int ETH_TYPE_OFF   = 12;
  localparam int IPV4_MIN_HDR   = 20;
  localparam int TCP_HDR_BYTES  = 20;
  localparam int UDP_HDR_BYTES  = 8;

  localparam int OFF_W      = 16;
  localparam int LEN_W      = OFF_W + 1;
  localparam int IHL_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IPNUM_ICMP     = 8'd1;
  localparam logic [7:0]  IPNUM_TCP      = 8'd6;
  localparam logic [7:0]  IPNUM_UDP      = 8'd17;

  typedef enum logic [1:0] {
    VERDICT_DROP     = 2'd0,
    VERDICT_FILTERED = 2'd1,
    VERDICT_ACCEPTED = 2'd2
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ACTIVE = 4'd0,
    CFG_MATCH_SRC_EN  = 4'd1,
    CFG_SRC_ADDR      = 4'd2,
    CFG_MATCH_DST_EN  = 4'd3,
    CFG_DST_ADDR      = 4'd4,
    CFG_SPORT         = 4'd5,
    CFG_DPORT         = 4'd6,
    CFG_PROTO         = 4'd7
  } cfg_reg_e;

  // parsed view of a frame, valid on its last word
  typedef struct packed {
    logic        hdr_ok;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto;
    logic [7:0]  ttl;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] icmp_type_code;
  } hdr_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] record_index;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto_num;
    logic [15:0] src_port_out;
    logic [15:0] dst_port_out;
    logic [7:0]  time_to_live;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] tcp_seq_num;
    logic [31:0] tcp_ack_num;
    logic [15:0] icmp_type_code;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/iphpf_ifs.sv
`default_nettype none

interface iphpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface iphpf_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [31:0] record_index;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  proto_num;
  logic [15:0] src_port_out;
  logic [15:0] dst_port_out;
  logic [7:0]  time_to_live;
  logic [7:0]  tcp_flag_bits;
  logic [31:0] tcp_seq_num;
  logic [31:0] tcp_ack_num;
  logic [15:0] icmp_type_code;

  modport source (
    output valid, input ready,
    output verdict, output record_index, output src_addr, output dst_addr,
    output proto_num, output src_port_out, output dst_port_out, output time_to_live,
    output tcp_flag_bits, output tcp_seq_num, output tcp_ack_num, output icmp_type_code
  );
  modport sink (
    input valid, output ready,
    input verdict, input record_index, input src_addr, input dst_addr,
    input proto_num, input src_port_out, input dst_port_out, input time_to_live,
    input tcp_flag_bits, input tcp_seq_num, input tcp_ack_num, input icmp_type_code
  );
endinterface

`default_nettype wire

// File: rtl/iphpf_parser.sv
`default_nettype none

module iphpf_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  output iphpf_pkg::hdr_t        hdr_o
);

  logic [iphpf_pkg::OFF_W-1:0] off_q, off_d;
  logic [15:0]                 ether_q, ether_d;
  logic [iphpf_pkg::IHL_W-1:0] ihl_q, ihl_d;
  logic [7:0]                  ttl_q, ttl_d, proto_q, proto_d, flags_q, flags_d;
  logic [31:0]                 src_q, src_d, dst_q, dst_d;
  logic [31:0]                 word0_q, word0_d, seq_q, seq_d, ack_q, ack_d;

  logic [iphpf_pkg::OFF_W-1:0] tp_start, tp_off;
  logic [iphpf_pkg::LEN_W-1:0] len, need;

  always_comb begin
    off_d   = (off_q == '1) ? off_q : off_q + 1'b1;
    ether_d = ether_q;
    ihl_d   = ihl_q;
    ttl_d   = ttl_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    word0_d = word0_q;
    seq_d   = seq_q;
    ack_d   = ack_q;
    flags_d = flags_q;

    tp_start = iphpf_pkg::OFF_W'(iphpf_pkg::ETH_HDR_BYTES)
             + {{(iphpf_pkg::OFF_W-iphpf_pkg::IHL_W){1'b0}}, ihl_q};
    tp_off   = off_q - tp_start;

    if (off_q == iphpf_pkg::OFF_W'(iphpf_pkg::ETH_TYPE_OFF)) begin
      ether_d = {byte_i, 8'h00};
    end else if (off_q == iphpf_pkg::OFF_W'(iphpf_pkg::ETH_TYPE_OFF + 1)) begin
      ether_d = ether_q | {8'h00, byte_i};
    end else if (off_q == iphpf_pkg::OFF_W'(iphpf_pkg::ETH_HDR_BYTES)) begin
      ihl_d = {byte_i[3:0], 2'b00};
    end else if (off_q == iphpf_pkg::OFF_W'(iphpf_pkg::ETH_HDR_BYTES + 8)) begin
      ttl_d = byte_i;
    end else if (off_q == iphpf_pkg::OFF_W'(iphpf_pkg::ETH_HDR_BYTES + 9)) begin
      proto_d = byte_i;
    end else if (off_q >= iphpf_pkg::OFF_W'(iphpf_pkg::ETH_HDR_BYTES + 12) &&
                 off_q <  iphpf_pkg::OFF_W'(iphpf_pkg::ETH_HDR_BYTES + 16)) begin
      src_d = {src_q[23:0], byte_i};
    end else if (off_q >= iphpf_pkg::OFF_W'(iphpf_pkg::ETH_HDR_BYTES + 16) &&
                 off_q <  iphpf_pkg::OFF_W'(iphpf_pkg::ETH_HDR_BYTES + 20)) begin
      dst_d = {dst_q[23:0], byte_i};
    end else if (ihl_q >= iphpf_pkg::IHL_W'(iphpf_pkg::IPV4_MIN_HDR) &&
                 off_q >= tp_start) begin
      // transport header: word0 (ports / icmp), seq, ack, flags at byte 13
      if (tp_off < 16'd4) begin
        word0_d = {word0_q[23:0], byte_i};
      end else if (tp_off < 16'd8) begin
        seq_d = {seq_q[23:0], byte_i};
      end else if (tp_off < 16'd12) begin
        ack_d = {ack_q[23:0], byte_i};
      end else if (tp_off == 16'd13) begin
        flags_d = byte_i;
      end
    end

    // frame summary from the updated state, used on the last word
    len  = {1'b0, off_q} + 1'b1;
    need = iphpf_pkg::LEN_W'(iphpf_pkg::ETH_HDR_BYTES)
         + {{(iphpf_pkg::LEN_W-iphpf_pkg::IHL_W){1'b0}}, ihl_d};

    hdr_o                = '0;
    hdr_o.hdr_ok         = (len >= iphpf_pkg::LEN_W'(iphpf_pkg::ETH_HDR_BYTES +
                                                     iphpf_pkg::IPV4_MIN_HDR)) &&
                           (ether_d == iphpf_pkg::ETHERTYPE_IPV4) &&
                           (ihl_d >= iphpf_pkg::IHL_W'(iphpf_pkg::IPV4_MIN_HDR));
    hdr_o.src_addr       = src_d;
    hdr_o.dst_addr       = dst_d;
    hdr_o.proto          = proto_d;
    hdr_o.ttl            = ttl_d;
    if (proto_d == iphpf_pkg::IPNUM_TCP) begin
      if (len >= need + iphpf_pkg::LEN_W'(iphpf_pkg::TCP_HDR_BYTES)) begin
        hdr_o.sport = word0_d[31:16];
        hdr_o.dport = word0_d[15:0];
        hdr_o.flags = flags_d;
        hdr_o.seq   = seq_d;
        hdr_o.ack   = ack_d;
      end
    end else if (proto_d == iphpf_pkg::IPNUM_UDP) begin
      if (len >= need + iphpf_pkg::LEN_W'(iphpf_pkg::UDP_HDR_BYTES)) begin
        hdr_o.sport = word0_d[31:16];
        hdr_o.dport = word0_d[15:0];
      end
    end else if (proto_d == iphpf_pkg::IPNUM_ICMP) begin
      if (len >= need + iphpf_pkg::LEN_W'(iphpf_pkg::ICMP_HDR_BYTES)) begin
        hdr_o.icmp_type_code = word0_d[31:16];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      ether_q <= '0;
      ihl_q   <= '0;
      ttl_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      word0_q <= '0;
      seq_q   <= '0;
      ack_q   <= '0;
      flags_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        off_q   <= '0;
        ether_q <= '0;
        ihl_q   <= '0;
        ttl_q   <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        word0_q <= '0;
        seq_q   <= '0;
        ack_q   <= '0;
        flags_q <= '0;
      end else begin
        off_q   <= off_d;
        ether_q <= ether_d;
        ihl_q   <= ihl_d;
        ttl_q   <= ttl_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        word0_q <= word0_d;
        seq_q   <= seq_d;
        ack_q   <= ack_d;
        flags_q <= flags_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/iphpf_verdict.sv
`default_nettype none

module iphpf_verdict (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [iphpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [iphpf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                             commit_i,
  input  wire iphpf_pkg::hdr_t                  hdr_i,
  output iphpf_pkg::result_t                    res_o
);

  logic        active_q, src_en_q, dst_en_q;
  logic [31:0] src_addr_q, dst_addr_q;
  logic [15:0] sport_q, dport_q;
  logic [7:0]  proto_q;
  logic [31:0] count_q;
  logic        pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      src_en_q   <= 1'b0;
      src_addr_q <= '0;
      dst_en_q   <= 1'b0;
      dst_addr_q <= '0;
      sport_q    <= '0;
      dport_q    <= '0;
      proto_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        iphpf_pkg::CFG_FILTER_ACTIVE: active_q   <= cfg_data_i[0];
        iphpf_pkg::CFG_MATCH_SRC_EN:  src_en_q   <= cfg_data_i[0];
        iphpf_pkg::CFG_SRC_ADDR:      src_addr_q <= cfg_data_i;
        iphpf_pkg::CFG_MATCH_DST_EN:  dst_en_q   <= cfg_data_i[0];
        iphpf_pkg::CFG_DST_ADDR:      dst_addr_q <= cfg_data_i;
        iphpf_pkg::CFG_SPORT:         sport_q    <= cfg_data_i[15:0];
        iphpf_pkg::CFG_DPORT:         dport_q    <= cfg_data_i[15:0];
        iphpf_pkg::CFG_PROTO:         proto_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pass = 1'b1;
    if (active_q) begin
      if (src_en_q && src_addr_q != hdr_i.src_addr) pass = 1'b0;
      if (dst_en_q && dst_addr_q != hdr_i.dst_addr) pass = 1'b0;
      if (sport_q != '0 && sport_q != hdr_i.sport) pass = 1'b0;
      if (dport_q != '0 && dport_q != hdr_i.dport) pass = 1'b0;
      if (proto_q != '0 && proto_q != hdr_i.proto) pass = 1'b0;
    end

    res_o = '0;
    res_o.verdict = iphpf_pkg::VERDICT_DROP;
    if (hdr_i.hdr_ok) begin
      res_o.verdict        = pass ? iphpf_pkg::VERDICT_ACCEPTED : iphpf_pkg::VERDICT_FILTERED;
      res_o.record_index   = pass ? count_q + 1'b1 : '0;
      res_o.src_addr       = hdr_i.src_addr;
      res_o.dst_addr       = hdr_i.dst_addr;
      res_o.proto_num      = hdr_i.proto;
      res_o.src_port_out   = hdr_i.sport;
      res_o.dst_port_out   = hdr_i.dport;
      res_o.time_to_live   = hdr_i.ttl;
      res_o.tcp_flag_bits  = hdr_i.flags;
      res_o.tcp_seq_num    = hdr_i.seq;
      res_o.tcp_ack_num    = hdr_i.ack;
      res_o.icmp_type_code = hdr_i.icmp_type_code;
    end
  end

  // running record index, wraps at 2^32
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit_i && hdr_i.hdr_ok && pass) begin
      count_q <= count_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ipv4_header_parse_filter.sv
// IPv4 header parser and 5-tuple filter.
// frame_i carries one frame byte per word, last_byte marking the final captured
// byte; result_o gives one word per frame, on its last byte: verdict, record
// index and the parsed IPv4 and TCP/UDP/ICMP fields (zero where absent).
// Filter registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while the block is idle, which the block does not enforce;
// indexes past the register list are ignored. A frame's result word becomes
// valid once its last byte passes the input register, then the result register.
// Throughput: one byte per cycle unless a final byte is held (below); each
// byte is parsed in one pass of compare and capture logic between them.
// When result_o stalls, non-final bytes keep flowing; a final byte waits in the
// input register until the result register frees, and frame_i.ready drops.
// Reset clears the byte offset, captured fields, filter registers and the
// record counter; the block is ready for a byte as soon as reset is released.
`default_nettype none

module ipv4_header_parse_filter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  iphpf_byte_if.sink                            frame_i,
  iphpf_result_if.source                        result_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [iphpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [iphpf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic               in_vld_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               adv;
  logic               out_vld_q, out_vld_d;
  iphpf_pkg::result_t out_q;
  iphpf_pkg::hdr_t    hdr;
  iphpf_pkg::result_t res;

  // a final byte needs the result register free
  assign adv           = in_vld_q && (!in_last_q || !out_vld_q || result_o.ready);
  assign frame_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (frame_i.ready) begin
      in_vld_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid && frame_i.ready) begin
      in_byte_q <= frame_i.frame_byte;
      in_last_q <= frame_i.last_byte;
    end
  end

  iphpf_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .hdr_o  (hdr)
  );

  iphpf_verdict u_verdict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .commit_i   (adv && in_last_q),
    .hdr_i      (hdr),
    .res_o      (res)
  );

  always_comb begin
    out_vld_d = out_vld_q && !result_o.ready;
    if (adv && in_last_q) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_q <= res;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.verdict        = out_q.verdict;
  assign result_o.record_index   = out_q.record_index;
  assign result_o.src_addr       = out_q.src_addr;
  assign result_o.dst_addr       = out_q.dst_addr;
  assign result_o.proto_num      = out_q.proto_num;
  assign result_o.src_port_out   = out_q.src_port_out;
  assign result_o.dst_port_out   = out_q.dst_port_out;
  assign result_o.time_to_live   = out_q.time_to_live;
  assign result_o.tcp_flag_bits  = out_q.tcp_flag_bits;
  assign result_o.tcp_seq_num    = out_q.tcp_seq_num;
  assign result_o.tcp_ack_num    = out_q.tcp_ack_num;
  assign result_o.icmp_type_code = out_q.icmp_type_code;

`ifndef ASSERT_OFF
  a_last_makes_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_last_q |=> out_vld_q)
    else $error("final byte did not produce a result word");

  a_drop_is_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.verdict == iphpf_pkg::VERDICT_DROP |->
      out_q.record_index == '0 && out_q.src_addr == '0 && out_q.proto_num == '0)
    else $error("dropped frame carries nonzero fields");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> frame_i.ready)
    else $error("input stage empty but not ready");

  a_filtered_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.verdict == iphpf_pkg::VERDICT_FILTERED |->
      out_q.record_index == '0)
    else $error("filtered frame carries a record index");
`endif

endmodule

`default_nettype wire
